[src/velocity_ghost_cell_boundary_fill_top_assert.svh]
// assertion macros shared by the boundary fill rtl
// expects a clock named clk and an active low reset named rst_n in scope
`ifndef VELOCITY_GHOST_CELL_BOUNDARY_FILL_TOP_ASSERT_SVH
`define VELOCITY_GHOST_CELL_BOUNDARY_FILL_TOP_ASSERT_SVH

// same cycle implication, off during reset
`define VGC_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next cycle implication, off during reset
`define VGC_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

// next cycle implication that also checks the reset itself
`define VGC_ASSERT_ALWAYS(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

[src/vgcbf_pkg.sv]
// shared widths, codes and stage payload types of the boundary fill block
// no dependencies
package vgcbf_pkg;

  localparam int VB        = 32;
  localparam int SQ_W      = 2 * VB + 1;
  localparam int DEN_W     = SQ_W + 1;
  localparam int LO_W      = VB;
  localparam int HI_W      = SQ_W - LO_W;
  localparam int NUM_W     = 3 * VB + 3;
  localparam int MAG_W     = NUM_W - 1;
  localparam int Q_W       = VB;
  localparam int DIV_STEPS = Q_W;
  localparam int NFACE     = 6;
  localparam int IDX_W     = 3;

  typedef enum logic [1:0] {
    OP_GHOST  = 2'd0,
    OP_FACE   = 2'd1,
    OP_CORNER = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    M_FIXED = 3'd0,
    M_COPY  = 3'd1,
    M_CLAMP = 3'd2,
    M_RAD   = 3'd3,
    M_EVEN  = 3'd4,
    M_ODD   = 3'd5,
    M_NONE  = 3'd6,
    M_NONE2 = 3'd7
  } mode_t;

  localparam logic [2:0] F_XLO = 3'd0;
  localparam logic [2:0] F_YLO = 3'd1;
  localparam logic [2:0] F_ZLO = 3'd2;
  localparam logic [2:0] F_XHI = 3'd3;
  localparam logic [2:0] F_YHI = 3'd4;
  localparam logic [2:0] F_ZHI = 3'd5;

  localparam logic [IDX_W-1:0] REG_MODES     = 3'd0;
  localparam logic [IDX_W-1:0] REG_FIX_FIRST = 3'd1;
  localparam logic [IDX_W-1:0] REG_FIX_LAST  = 3'd6;

  typedef struct packed {
    logic                 rad;
    logic                 wr;
    logic                 land;
    logic signed [VB-1:0] direct;
  } side_t;

  typedef struct packed {
    logic signed [VB:0]   dt;
    logic signed [VB:0]   dx;
    logic signed [VB-1:0] de;
    logic signed [VB-1:0] on;
    logic signed [VB-1:0] no;
  } rad_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   q;
    logic [DEN_W-1:0] den;
    logic             neg;
    side_t            side;
  } div_t;

endpackage

[src/velocity_ghost_cell_boundary_fill_top.sv]
// pipeline: decode stage, radiation weight stages, divider stages, output register
// throughput: one word per cycle; a stalled output holds the whole pipeline
// the divider takes one quotient bit per stage, in 32 stages
// reset: synchronous active low, clears valid bits and all configuration registers
// top level of the boundary fill block: configuration registers, pipeline, output register
// depends on vgcbf_pkg, vgcbf_front, vgcbf_mul, vgcbf_div and the assertion macro header
`include "velocity_ghost_cell_boundary_fill_top_assert.svh"

module velocity_ghost_cell_boundary_fill_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_op,
  input  logic [2:0]                      in_face,
  input  logic                            in_corner_north,
  input  logic                            in_land_mask,
  input  logic signed [vgcbf_pkg::VB-1:0] in_source_value,
  input  logic signed [vgcbf_pkg::VB-1:0] in_second_value,
  input  logic signed [vgcbf_pkg::VB-1:0] in_outside_new,
  input  logic signed [vgcbf_pkg::VB-1:0] in_near_new,
  input  logic signed [vgcbf_pkg::VB-1:0] in_near_old,
  input  logic signed [vgcbf_pkg::VB-1:0] in_far_old,
  input  logic signed [vgcbf_pkg::VB-1:0] in_grad_first,
  input  logic signed [vgcbf_pkg::VB-1:0] in_grad_second,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [vgcbf_pkg::VB-1:0] out_value,
  output logic                            out_written,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vgcbf_pkg::IDX_W-1:0]     cfg_index,
  input  logic [vgcbf_pkg::VB-1:0]        cfg_data
);
  import vgcbf_pkg::*;

  logic                        en;
  logic [3*NFACE-1:0]          face_modes_r;
  logic [NFACE-1:0][VB-1:0]    fixed_value_r;
  logic                        fr_vld;
  side_t                       fr_side;
  rad_t                        fr_rad;
  logic                        mu_vld;
  div_t                        mu_div;
  logic                        dv_vld;
  div_t                        dv_div;
  logic signed [VB:0]          q_signed;
  logic signed [VB-1:0]        val;
  logic                        out_valid_r;
  logic signed [VB-1:0]        out_value_r;
  logic                        out_written_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_modes_r  <= '0;
      fixed_value_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MODES) begin
        face_modes_r <= cfg_data[3*NFACE-1:0];
      end else if ((cfg_index >= REG_FIX_FIRST) && (cfg_index <= REG_FIX_LAST)) begin
        fixed_value_r[cfg_index - REG_FIX_FIRST] <= cfg_data;
      end
    end
  end

  vgcbf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_vld       (in_valid),
    .op           (in_op),
    .face         (in_face),
    .corner_north (in_corner_north),
    .land_mask    (in_land_mask),
    .source_value (in_source_value),
    .second_value (in_second_value),
    .outside_new  (in_outside_new),
    .near_new     (in_near_new),
    .near_old     (in_near_old),
    .far_old      (in_far_old),
    .grad_first   (in_grad_first),
    .grad_second  (in_grad_second),
    .face_modes   (face_modes_r),
    .fixed_value  (fixed_value_r),
    .vld_r        (fr_vld),
    .side_r       (fr_side),
    .rad_r        (fr_rad)
  );

  vgcbf_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (fr_vld),
    .in_side (fr_side),
    .in_rad  (fr_rad),
    .vld_r   (mu_vld),
    .div_r   (mu_div)
  );

  vgcbf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (mu_vld),
    .in_div (mu_div),
    .vld_r  (dv_vld),
    .div_r  (dv_div)
  );

  assign q_signed = dv_div.neg ? -$signed({1'b0, dv_div.q}) : $signed({1'b0, dv_div.q});
  assign val      = dv_div.side.rad ? q_signed[VB-1:0] : dv_div.side.direct;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r   <= (dv_div.side.wr && dv_div.side.land) ? val : '0;
      out_written_r <= dv_div.side.wr;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_written = out_written_r;

  `VGC_ASSERT_NOW(a_top_unwritten_zero, out_valid_r && !out_written_r, out_value_r == '0, "unwritten word has nonzero value")
  `VGC_ASSERT_NEXT(a_top_accept_enters, in_valid && !in_stall, fr_vld, "accepted word missing from decode stage")
  `VGC_ASSERT_ALWAYS(a_top_reset_empty, !rst_n, !out_valid_r, "output valid after reset")

endmodule

[src/vgcbf_front.sv]
// decode stage: rule selection, direct values and radiation differences
// depends on vgcbf_pkg
module vgcbf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [1:0]                     op,
  input  logic [2:0]                     face,
  input  logic                           corner_north,
  input  logic                           land_mask,
  input  logic signed [vgcbf_pkg::VB-1:0] source_value,
  input  logic signed [vgcbf_pkg::VB-1:0] second_value,
  input  logic signed [vgcbf_pkg::VB-1:0] outside_new,
  input  logic signed [vgcbf_pkg::VB-1:0] near_new,
  input  logic signed [vgcbf_pkg::VB-1:0] near_old,
  input  logic signed [vgcbf_pkg::VB-1:0] far_old,
  input  logic signed [vgcbf_pkg::VB-1:0] grad_first,
  input  logic signed [vgcbf_pkg::VB-1:0] grad_second,
  input  logic [3*vgcbf_pkg::NFACE-1:0]   face_modes,
  input  logic [vgcbf_pkg::NFACE-1:0][vgcbf_pkg::VB-1:0] fixed_value,
  output logic                           vld_r,
  output vgcbf_pkg::side_t               side_r,
  output vgcbf_pkg::rad_t                rad_r
);
  import vgcbf_pkg::*;

  logic                 face_ok;
  logic [2:0]           fsel;
  mode_t                mode;
  mode_t                ymode;
  logic                 zface;
  logic                 xface;
  logic signed [VB-1:0] fixv;
  logic signed [VB-1:0] oddv;
  logic signed [VB:0]   sum2;
  logic signed [VB:0]   dt;
  logic signed [VB:0]   dx;
  logic signed [VB:0]   dtz;
  logic signed [VB:0]   gs;
  logic                 clash;
  side_t                side_nxt;
  rad_t                 rad_nxt;

  assign face_ok = (face <= F_ZHI);
  assign fsel    = face_ok ? face : F_XLO;
  assign mode    = face_ok ? mode_t'(face_modes[3*fsel +: 3]) : M_NONE;
  assign ymode   = corner_north ? mode_t'(face_modes[3*F_YHI +: 3])
                                : mode_t'(face_modes[3*F_YLO +: 3]);
  assign zface   = (face == F_ZLO) || (face == F_ZHI);
  assign xface   = (face == F_XLO) || (face == F_XHI);
  assign fixv    = fixed_value[fsel];
  assign oddv    = (source_value == {1'b1, {(VB-1){1'b0}}}) ? {1'b0, {(VB-1){1'b1}}}
                                                           : -source_value;
  assign sum2    = {source_value[VB-1], source_value} + {second_value[VB-1], second_value};

  // radiation differences, tendency zeroed on a sign clash
  assign dt    = {near_new[VB-1], near_new} - {near_old[VB-1], near_old};
  assign dx    = {near_old[VB-1], near_old} - {far_old[VB-1], far_old};
  assign gs    = {grad_first[VB-1], grad_first} + {grad_second[VB-1], grad_second};
  assign clash = (dt != '0) && (dx != '0) && (dt[VB] != dx[VB]);
  assign dtz   = clash ? '0 : dt;

  always_comb begin
    rad_nxt.dt = dtz;
    rad_nxt.dx = dx;
    rad_nxt.de = ((dtz != '0) && (gs != '0) && (dtz[VB] == gs[VB])) ? grad_first
                                                                    : grad_second;
    rad_nxt.on = outside_new;
    rad_nxt.no = near_old;
  end

  always_comb begin
    side_nxt.rad    = 1'b0;
    side_nxt.wr     = 1'b0;
    side_nxt.land   = land_mask;
    side_nxt.direct = '0;
    if (face_ok) begin
      case (op_t'(op))
        OP_GHOST: begin
          case (mode)
            M_FIXED: begin
              side_nxt.direct = fixv;
              side_nxt.wr     = 1'b1;
            end
            M_COPY, M_EVEN: begin
              side_nxt.direct = source_value;
              side_nxt.wr     = 1'b1;
            end
            M_CLAMP: begin
              side_nxt.direct = source_value;
              side_nxt.wr     = !zface;
            end
            M_RAD: begin
              side_nxt.rad = !zface;
              side_nxt.wr  = !zface;
            end
            M_ODD: begin
              side_nxt.direct = oddv;
              side_nxt.wr     = 1'b1;
            end
            default: ;
          endcase
        end
        OP_FACE: begin
          if (xface) begin
            case (mode)
              M_FIXED: begin
                side_nxt.direct = fixv;
                side_nxt.wr     = 1'b1;
              end
              M_COPY: begin
                side_nxt.direct = source_value;
                side_nxt.wr     = 1'b1;
              end
              M_RAD: begin
                side_nxt.rad = 1'b1;
                side_nxt.wr  = 1'b1;
              end
              default: ;
            endcase
          end
        end
        OP_CORNER: begin
          if (xface && (mode != M_CLAMP) && (ymode != M_CLAMP)) begin
            side_nxt.direct = sum2[VB:1];
            side_nxt.wr     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      rad_r  <= rad_nxt;
    end
  end

endmodule

[src/vgcbf_mul.sv]
// radiation weights and weighted sum: squares, cff floor, split products
// depends on vgcbf_pkg; feeds the divider with magnitude, sign and denominator
module vgcbf_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  vgcbf_pkg::side_t in_side,
  input  vgcbf_pkg::rad_t  in_rad,
  output logic             vld_r,
  output vgcbf_pkg::div_t  div_r
);
  import vgcbf_pkg::*;

  // stage b: products
  logic signed [2*VB+1:0] dxsq_full;
  logic signed [2*VB-1:0] desq_full;
  logic signed [2*VB+1:0] cx_full;
  logic                   b_vld_r;
  side_t                  b_side_r;
  logic [SQ_W-1:0]        b_dxsq_r;
  logic [SQ_W-1:0]        b_desq_r;
  logic [SQ_W-1:0]        b_cx_r;
  logic signed [VB-1:0]   b_on_r;
  logic signed [VB-1:0]   b_no_r;

  assign dxsq_full = in_rad.dx * in_rad.dx;
  assign desq_full = in_rad.de * in_rad.de;
  assign cx_full   = in_rad.dt * in_rad.dx;

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r <= in_side;
      b_dxsq_r <= dxsq_full[SQ_W-1:0];
      b_desq_r <= SQ_W'(desq_full[2*VB-2:0]);
      b_cx_r   <= cx_full[SQ_W-1:0];
      b_on_r   <= in_rad.on;
      b_no_r   <= in_rad.no;
    end
  end

  // stage c: cff floored at one lsb
  logic [SQ_W-1:0]      cff_sum;
  logic                 c_vld_r;
  side_t                c_side_r;
  logic [SQ_W-1:0]      c_cff_r;
  logic [SQ_W-1:0]      c_cx_r;
  logic signed [VB-1:0] c_on_r;
  logic signed [VB-1:0] c_no_r;

  assign cff_sum = b_dxsq_r + b_desq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= b_side_r;
      c_cff_r  <= (cff_sum == '0) ? SQ_W'(1) : cff_sum;
      c_cx_r   <= b_cx_r;
      c_on_r   <= b_on_r;
      c_no_r   <= b_no_r;
    end
  end

  // stage d: denominator and partial products
  logic signed [VB+LO_W:0] pl_cff;
  logic signed [VB+HI_W:0] ph_cff;
  logic signed [VB+LO_W:0] pl_cx;
  logic signed [VB+HI_W:0] ph_cx;
  logic                    d_vld_r;
  side_t                   d_side_r;
  logic [DEN_W-1:0]        d_den_r;
  logic signed [VB+LO_W:0] d_pl_cff_r;
  logic signed [VB+HI_W:0] d_ph_cff_r;
  logic signed [VB+LO_W:0] d_pl_cx_r;
  logic signed [VB+HI_W:0] d_ph_cx_r;

  assign pl_cff = $signed({1'b0, c_cff_r[LO_W-1:0]}) * c_on_r;
  assign ph_cff = $signed({1'b0, c_cff_r[SQ_W-1:LO_W]}) * c_on_r;
  assign pl_cx  = $signed({1'b0, c_cx_r[LO_W-1:0]}) * c_no_r;
  assign ph_cx  = $signed({1'b0, c_cx_r[SQ_W-1:LO_W]}) * c_no_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_side_r   <= c_side_r;
      d_den_r    <= {1'b0, c_cff_r} + {1'b0, c_cx_r};
      d_pl_cff_r <= pl_cff;
      d_ph_cff_r <= ph_cff;
      d_pl_cx_r  <= pl_cx;
      d_ph_cx_r  <= ph_cx;
    end
  end

  // stage e: recombine halves
  logic                   e_vld_r;
  side_t                  e_side_r;
  logic [DEN_W-1:0]       e_den_r;
  logic signed [NUM_W-1:0] e_p1_r;
  logic signed [NUM_W-1:0] e_p2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r <= d_side_r;
      e_den_r  <= d_den_r;
      e_p1_r   <= (NUM_W'(d_ph_cff_r) <<< LO_W) + NUM_W'(d_pl_cff_r);
      e_p2_r   <= (NUM_W'(d_ph_cx_r) <<< LO_W) + NUM_W'(d_pl_cx_r);
    end
  end

  // stage f: numerator
  logic                    f_vld_r;
  side_t                   f_side_r;
  logic [DEN_W-1:0]        f_den_r;
  logic signed [NUM_W-1:0] f_num_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f_side_r <= e_side_r;
      f_den_r  <= e_den_r;
      f_num_r  <= e_p1_r + e_p2_r;
    end
  end

  // stage g: sign and magnitude for the divider
  logic                    num_neg;
  logic signed [NUM_W-1:0] mag_full;
  logic [MAG_W-1:0]        mag;
  div_t                    div_nxt;

  assign num_neg  = f_num_r[NUM_W-1];
  assign mag_full = num_neg ? -f_num_r : f_num_r;
  assign mag      = mag_full[MAG_W-1:0];

  always_comb begin
    div_nxt.rem  = mag[MAG_W-1:Q_W];
    div_nxt.low  = mag[Q_W-1:0];
    div_nxt.q    = '0;
    div_nxt.den  = f_den_r;
    div_nxt.neg  = num_neg;
    div_nxt.side = f_side_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (en) begin
      b_vld_r <= in_vld;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      vld_r   <= f_vld_r;
    end
  end

endmodule

[src/vgcbf_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on vgcbf_pkg and the assertion macro header
`include "velocity_ghost_cell_boundary_fill_top_assert.svh"

module vgcbf_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  vgcbf_pkg::div_t in_div,
  output logic            vld_r,
  output vgcbf_pkg::div_t div_r
);
  import vgcbf_pkg::*;

  logic [DIV_STEPS-1:0] st_vld_r;
  div_t                 st_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    div_t             cur;
    div_t             nxt;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic             cur_vld;

    if (k == 0) begin : g_first
      assign cur     = in_div;
      assign cur_vld = in_vld;
    end else begin : g_rest
      assign cur     = st_r[k-1];
      assign cur_vld = st_vld_r[k-1];
    end

    assign shifted = {cur.rem, cur.low[Q_W-1]};
    assign diff    = shifted - {1'b0, cur.den};
    assign ge      = (shifted >= {1'b0, cur.den});

    always_comb begin
      nxt     = cur;
      nxt.rem = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      nxt.low = {cur.low[Q_W-2:0], 1'b0};
      nxt.q   = {cur.q[Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[k] <= 1'b0;
      end else if (en) begin
        st_vld_r[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign vld_r = st_vld_r[DIV_STEPS-1];
  assign div_r = st_r[DIV_STEPS-1];

  `VGC_ASSERT_NOW(a_div_entry_fits, in_vld && in_div.side.rad, in_div.rem < in_div.den, "quotient would not fit")
  `VGC_ASSERT_NOW(a_div_rem_bound, vld_r && div_r.side.rad, div_r.rem < div_r.den, "remainder not below divisor")
  `VGC_ASSERT_NOW(a_div_pos_range, vld_r && div_r.side.rad && !div_r.neg, !div_r.q[Q_W-1], "positive quotient out of range")

endmodule

[dv/velocity_ghost_cell_boundary_fill_top_tb.sv]
// self-checking testbench for the boundary fill block: directed and random cells
// under several face mode settings, predicted by a scoreboard class
// depends on vgcbf_pkg and velocity_ghost_cell_boundary_fill_top
module velocity_ghost_cell_boundary_fill_top_tb;
  import vgcbf_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [VB-1:0] val_t;

  typedef struct {
    logic [1:0] op;
    logic [2:0] face;
    logic       north;
    logic       land;
    val_t       src, sec, on, nn, no, fo, g1, g2;
  } cell_t;

  typedef struct {
    val_t value;
    logic written;
  } fill_t;

  class fill_scoreboard;
    logic [17:0] modes;
    val_t        fixed[NFACE];
    fill_t       pending_fills[$];
    int          errors;
    int          checked;
    int          written_cnt;
    int          mode_seen[8];

    function val_t clip(wide_t v);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (VB-1)) - wide_t'(1);
      lo = -(wide_t'(1) <<< (VB-1));
      if (v > hi) return val_t'(hi);
      if (v < lo) return val_t'(lo);
      return val_t'(v);
    endfunction

    function wide_t radiate(cell_t c);
      wide_t on, nn, no, fo, g1, g2, dt, dx, s, de, cff, cx;
      on = c.on; nn = c.nn; no = c.no; fo = c.fo; g1 = c.g1; g2 = c.g2;
      dt = nn - no;
      dx = no - fo;
      if (dt != 0 && dx != 0 && ((dt < 0) != (dx < 0))) dt = 0;
      s = g1 + g2;
      de = (dt != 0 && s != 0 && ((dt < 0) == (s < 0))) ? g1 : g2;
      cff = dx * dx + de * de;
      if (cff == 0) cff = 1;
      cx = dt * dx;
      return (cff * on + cx * no) / (cff + cx);
    endfunction

    function void note_cell(cell_t c);
      mode_t m, ym;
      logic  zf, xf, wr;
      wide_t v, a, b;
      fill_t f;
      wr = 0;
      v = 0;
      if (c.face <= F_ZHI) begin
        m = mode_t'(modes[3*c.face +: 3]);
        mode_seen[m]++;
        zf = (c.face == F_ZLO || c.face == F_ZHI);
        xf = (c.face == F_XLO || c.face == F_XHI);
        if (c.op == OP_GHOST) begin
          if (m == M_FIXED) begin
            v = fixed[c.face]; wr = 1;
          end else if (m == M_COPY || (m == M_CLAMP && !zf) || m == M_EVEN) begin
            v = c.src; wr = 1;
          end else if (m == M_RAD && !zf) begin
            v = radiate(c); wr = 1;
          end else if (m == M_ODD) begin
            a = c.src; v = -a; wr = 1;
          end
        end else if (c.op == OP_FACE && xf) begin
          if (m == M_FIXED) begin
            v = fixed[c.face]; wr = 1;
          end else if (m == M_COPY) begin
            v = c.src; wr = 1;
          end else if (m == M_RAD) begin
            v = radiate(c); wr = 1;
          end
        end else if (c.op == OP_CORNER && xf) begin
          ym = mode_t'(modes[3*(c.north ? F_YHI : F_YLO) +: 3]);
          if (m != M_CLAMP && ym != M_CLAMP) begin
            a = c.src; b = c.sec; v = (a + b) >>> 1; wr = 1;
          end
        end
      end
      if (!wr || !c.land) v = 0;
      f.value = clip(v);
      f.written = wr;
      pending_fills.push_back(f);
    endfunction

    function void check_fill(val_t value, logic written);
      fill_t e;
      if (pending_fills.size() == 0) begin
        $display("%0t: unexpected word value %0d written %0b", $time, value, written);
        errors++;
        return;
      end
      e = pending_fills.pop_front();
      checked++;
      if (written) written_cnt++;
      if (value !== e.value) begin
        $display("%0t: value mismatch expected %0d actual %0d", $time, e.value, value);
        errors++;
      end
      if (written !== e.written) begin
        $display("%0t: written mismatch expected %0b actual %0b", $time, e.written, written);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_corner_north, in_land_mask;
  logic [1:0] in_op;
  logic [2:0] in_face;
  val_t in_source_value, in_second_value, in_outside_new, in_near_new;
  val_t in_near_old, in_far_old, in_grad_first, in_grad_second;
  logic out_valid, out_stall, out_written;
  val_t out_value;
  logic cfg_valid, cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [VB-1:0] cfg_data;

  velocity_ghost_cell_boundary_fill_top dut (.*);

  fill_scoreboard sb;
  bit quiet;
  bit hold_now;
  int idle_cycles;
  int sent;

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_fill(out_value, out_written);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("watchdog: no progress, %0d words outstanding", sb.pending_fills.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_now = 0;
      end
      out_stall <= (!quiet && $urandom_range(99) < 7);
    end
  end

  function val_t pick_val();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      3: return $signed($urandom_range(600)) - 300;
      4: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  function cell_t rand_cell();
    cell_t c;
    if ($urandom_range(9) == 0) c.op = 2'($urandom_range(3));
    else c.op = 2'($urandom_range(2));
    c.face = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    c.north = 1'($urandom_range(1));
    c.land = ($urandom_range(7) != 0);
    c.src = pick_val(); c.sec = pick_val(); c.on = pick_val(); c.nn = pick_val();
    c.no = pick_val(); c.fo = pick_val(); c.g1 = pick_val(); c.g2 = pick_val();
    return c;
  endfunction

  function cell_t mk_cell(logic [1:0] op, logic [2:0] face, logic north, logic land,
                          val_t src, val_t sec, val_t nn, val_t no, val_t fo,
                          val_t g1, val_t g2);
    cell_t c;
    c.op = op; c.face = face; c.north = north; c.land = land;
    c.src = src; c.sec = sec; c.on = 32'sh0003_0000; c.nn = nn; c.no = no; c.fo = fo;
    c.g1 = g1; c.g2 = g2;
    return c;
  endfunction

  task send_cell(cell_t c);
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= c.op; in_face <= c.face; in_corner_north <= c.north; in_land_mask <= c.land;
    in_source_value <= c.src; in_second_value <= c.sec; in_outside_new <= c.on;
    in_near_new <= c.nn; in_near_old <= c.no; in_far_old <= c.fo;
    in_grad_first <= c.g1; in_grad_second <= c.g2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_cell(c);
    sent++;
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_fills.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task write_reg(logic [IDX_W-1:0] idx, logic [VB-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_MODES) sb.modes = data[17:0];
    else sb.fixed[idx - REG_FIX_FIRST] = data;
  endtask

  task set_config(logic [17:0] modes);
    write_reg(REG_MODES, {14'd0, modes});
    for (int f = 0; f < NFACE; f++) write_reg(IDX_W'(REG_FIX_FIRST + f), pick_val());
  endtask

  initial begin
    logic [17:0] m;
    sb = new();
    sb.modes = 0;
    foreach (sb.fixed[i]) sb.fixed[i] = 0;
    rst_n = 1'b0; in_valid = 1'b0; cfg_valid = 1'b0; cfg_index = 0; cfg_data = 0;
    in_op = 0; in_face = 0; in_corner_north = 0; in_land_mask = 0;
    in_source_value = 0; in_second_value = 0; in_outside_new = 0; in_near_new = 0;
    in_near_old = 0; in_far_old = 0; in_grad_first = 0; in_grad_second = 0;
    quiet = 0; hold_now = 0; idle_cycles = 0; sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // xlo fixed, ylo copy, zlo clamped, xhi radiation, yhi even, zhi odd
    set_config(18'o543210);
    for (int f = 0; f < 8; f++)
      send_cell(mk_cell(OP_GHOST, 3'(f), 0, 1, 32'sh8000_0000, 0, 5, 3, 1, 2, 2));
    send_cell(mk_cell(OP_GHOST, F_ZHI, 0, 1, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 0));
    send_cell(mk_cell(OP_GHOST, F_XHI, 0, 1, 0, 0, 9, 3, 7, 4, -1));
    send_cell(mk_cell(OP_GHOST, F_XHI, 0, 1, 0, 0, 3, 3, 3, 0, 0));
    send_cell(mk_cell(OP_GHOST, F_XHI, 0, 1, 0, 0, -4, 2, 5, -6, 1));
    send_cell(mk_cell(OP_FACE, F_XLO, 0, 1, 77, 0, 0, 0, 0, 0, 0));
    send_cell(mk_cell(OP_FACE, F_XHI, 0, 1, 77, 0, 32'sh7fff_ffff, 32'sh8000_0000,
                      32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_cell(mk_cell(OP_FACE, F_YLO, 0, 1, 77, 0, 0, 0, 0, 0, 0));
    send_cell(mk_cell(OP_CORNER, F_XLO, 0, 1, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0, 0, 0));
    send_cell(mk_cell(OP_CORNER, F_XHI, 1, 1, 32'sh8000_0000, -1, 0, 0, 0, 0, 0));
    send_cell(mk_cell(OP_CORNER, F_YLO, 1, 1, 5, 6, 0, 0, 0, 0, 0));
    send_cell(mk_cell(2'd3, F_XLO, 1, 1, 5, 6, 0, 0, 0, 0, 0));
    send_cell(mk_cell(OP_GHOST, F_YLO, 0, 0, 1234, 0, 0, 0, 0, 0, 0));
    send_cell(mk_cell(OP_GHOST, F_XLO, 0, 0, 1234, 0, 0, 0, 0, 0, 0));
    drain();

    // clamped x and y sides block corners, then none modes
    set_config(18'o762726);
    send_cell(mk_cell(OP_CORNER, F_XLO, 0, 1, 3, 4, 0, 0, 0, 0, 0));
    send_cell(mk_cell(OP_CORNER, F_XHI, 1, 1, 3, 4, 0, 0, 0, 0, 0));
    send_cell(mk_cell(OP_GHOST, F_ZLO, 0, 1, 3, 4, 0, 0, 0, 0, 0));
    send_cell(mk_cell(OP_GHOST, F_XLO, 0, 1, 3, 4, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: m = 18'o000000;
        1: m = 18'o777777;
        2: m = 18'o333333;
        3: m = 18'o030303;
        default: m = 18'($urandom_range(18'h3ffff));
      endcase
      set_config(m);
      quiet = (ph == 2);
      for (int i = 0; i < 195; i++) begin
        if (ph == 4 && i == 40) hold_now = 1;
        send_cell(rand_cell());
      end
      drain();
    end
    quiet = 0;

    $display("sent %0d cells, checked %0d words, %0d written", sent, sb.checked,
             sb.written_cnt);
    $display("modes per cell: fixed %0d copy %0d clamp %0d rad %0d even %0d odd %0d none %0d",
             sb.mode_seen[0], sb.mode_seen[1], sb.mode_seen[2], sb.mode_seen[3],
             sb.mode_seen[4], sb.mode_seen[5], sb.mode_seen[6] + sb.mode_seen[7]);
    if (sb.errors == 0 && sb.pending_fills.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
